// ----- design/dwell_time_mode_finder_defines.svh -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder assertion macros
// Shared property forms used by the checks at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef DWELL_TIME_MODE_FINDER_DEFINES_SVH
`define DWELL_TIME_MODE_FINDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/dtmf_pkg.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder package
// Widths, register map, default sizes and the types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dtmf_pkg;

   localparam int TIME_W   = 32;
   localparam int STATUS_W = 8;
   localparam int BIN_W    = 8;
   localparam int DATA_W   = 32;

   // Number of distinct bin indexes a row can carry.
   localparam int BIN_SPACE = 1 << BIN_W;

   localparam int NUM_BINS_DEFAULT = 256;
   localparam int QUEUE_DEPTH      = 4;

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_WINDOW_START = 2'd0;
   localparam logic [1:0] REG_WINDOW_END   = 2'd1;
   localparam logic [1:0] REG_STOP_CODE    = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]   window_start;
      logic [TIME_W-1:0]   window_end;
      logic [STATUS_W-1:0] stop_code;
   } cfg_type;

   typedef struct packed {
      logic [BIN_W-1:0]  bin;
      logic [TIME_W-1:0] amount;
      logic              add_en;
      logic              last;
   } job_type;

endpackage

`default_nettype wire

// ----- design/dtmf_csr.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder register file
// APB-style access to the window bounds and the stop status code.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmf_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [dtmf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [dtmf_pkg::DATA_W-1:0]     pwdata,
   output logic      [dtmf_pkg::DATA_W-1:0]     prdata,
   output logic                                 pready,
   output dtmf_pkg::cfg_type                    cfg
);

   logic [dtmf_pkg::TIME_W-1:0]   win_start_ff, win_start_in;
   logic [dtmf_pkg::TIME_W-1:0]   win_end_ff, win_end_in;
   logic [dtmf_pkg::STATUS_W-1:0] stop_code_ff, stop_code_in;
   logic                          wr_en;
   logic [1:0]                    reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      stop_code_in = stop_code_ff;
      prdata       = '0;
      unique case (reg_idx)
         dtmf_pkg::REG_WINDOW_START: begin
            prdata = win_start_ff;
            if (wr_en) begin
               win_start_in = pwdata;
            end
         end
         dtmf_pkg::REG_WINDOW_END: begin
            prdata = win_end_ff;
            if (wr_en) begin
               win_end_in = pwdata;
            end
         end
         dtmf_pkg::REG_STOP_CODE: begin
            prdata = {{(dtmf_pkg::DATA_W-dtmf_pkg::STATUS_W){1'b0}}, stop_code_ff};
            if (wr_en) begin
               stop_code_in = pwdata[dtmf_pkg::STATUS_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff   <= '1;
         stop_code_ff <= '0;
      end else begin
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         stop_code_ff <= stop_code_in;
      end
   end

   assign cfg.window_start = win_start_ff;
   assign cfg.window_end   = win_end_ff;
   assign cfg.stop_code    = stop_code_ff;

endmodule

`default_nettype wire

// ----- design/dtmf_front.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder front end
// Accepts log rows, clips each interval to the window and queues the work.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmf_front #(
   parameter int NUM_BINS = dtmf_pkg::NUM_BINS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dtmf_pkg::cfg_type             cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dtmf_pkg::TIME_W-1:0]   req_row_time,
   input  wire logic [dtmf_pkg::STATUS_W-1:0] req_row_status,
   input  wire logic [dtmf_pkg::BIN_W-1:0]    req_row_bin,
   input  wire logic                          req_row_last,
   input  wire logic                          q_full,
   output logic                               q_push,
   output dtmf_pkg::job_type                  q_job
);

   logic [dtmf_pkg::TIME_W-1:0]   prev_time_ff, prev_time_in;
   logic [dtmf_pkg::STATUS_W-1:0] prev_status_ff, prev_status_in;
   logic [dtmf_pkg::BIN_W-1:0]    prev_bin_ff, prev_bin_in;
   logic                          prev_valid_ff, prev_valid_in;

   logic                          accept;
   logic                          counted;
   logic                          in_range;
   logic [dtmf_pkg::TIME_W-1:0]   hi;
   logic [dtmf_pkg::TIME_W-1:0]   lo;
   logic                          add_en;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      counted  = prev_valid_ff && (prev_status_ff != cfg.stop_code)
                 && (prev_time_ff <= cfg.window_end);
      in_range = 32'(prev_bin_ff) < 32'(NUM_BINS);
      hi       = (req_row_time < cfg.window_end) ? req_row_time : cfg.window_end;
      lo       = (prev_time_ff > cfg.window_start) ? prev_time_ff : cfg.window_start;
      add_en   = counted && in_range && (hi > lo);

      q_job.bin    = add_en ? prev_bin_ff : '0;
      q_job.amount = hi - lo;
      q_job.add_en = add_en;
      q_job.last   = req_row_last;
      q_push       = accept && (add_en || req_row_last);

      prev_time_in   = prev_time_ff;
      prev_status_in = prev_status_ff;
      prev_bin_in    = prev_bin_ff;
      prev_valid_in  = prev_valid_ff;
      if (accept) begin
         if (req_row_last) begin
            prev_time_in   = '0;
            prev_status_in = '0;
            prev_bin_in    = '0;
            prev_valid_in  = 1'b0;
         end else begin
            prev_time_in   = req_row_time;
            prev_status_in = req_row_status;
            prev_bin_in    = req_row_bin;
            prev_valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff   <= '0;
         prev_status_ff <= '0;
         prev_bin_ff    <= '0;
         prev_valid_ff  <= 1'b0;
      end else begin
         prev_time_ff   <= prev_time_in;
         prev_status_ff <= prev_status_in;
         prev_bin_ff    <= prev_bin_in;
         prev_valid_ff  <= prev_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/dtmf_queue.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder work queue
// Short FIFO that decouples the front end from the accumulation back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dwell_time_mode_finder_defines.svh"

module dtmf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dtmf_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output dtmf_pkg::job_type      head_job
);

   localparam int DEPTH = dtmf_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);

   dtmf_pkg::job_type slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CNT_DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `DTMF_ASSERT_NOW(a_no_overflow, clock, reset, push, !full, "push into a full work queue")
   `DTMF_ASSERT_NOW(a_no_underflow, clock, reset, pop, head_valid, "pop from an empty work queue")

endmodule

`default_nettype wire

// ----- design/dtmf_back.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder back end
// Bin total read-modify-write with forwarding, running argmax and result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dwell_time_mode_finder_defines.svh"

module dtmf_back #(
   parameter int NUM_BINS = dtmf_pkg::NUM_BINS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire dtmf_pkg::job_type           q_job,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [dtmf_pkg::BIN_W-1:0]       rsp_best_bin,
   output logic [dtmf_pkg::TIME_W-1:0]      rsp_best_total
);

   // Rows carry an 8-bit bin, so no more entries than that can ever be hit.
   localparam int TBL_DEPTH = (NUM_BINS < dtmf_pkg::BIN_SPACE) ? NUM_BINS
                                                                 : dtmf_pkg::BIN_SPACE;
   localparam int AW = $clog2(TBL_DEPTH);
   localparam int TW = dtmf_pkg::TIME_W;

   logic [TW-1:0]          mem [TBL_DEPTH];
   logic [TW-1:0]          rd_data_ff;
   logic [TBL_DEPTH-1:0]   valid_ff, valid_in;

   logic                   b_vld_ff, b_vld_in;
   dtmf_pkg::job_type      b_job_ff, b_job_in;

   logic                   fwd_vld_ff, fwd_vld_in;
   logic [AW-1:0]          fwd_addr_ff, fwd_addr_in;
   logic [TW-1:0]          fwd_data_ff, fwd_data_in;

   logic [dtmf_pkg::BIN_W-1:0] lead_bin_ff, lead_bin_in;
   logic [TW-1:0]              lead_total_ff, lead_total_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dtmf_pkg::BIN_W-1:0] rsp_bin_ff, rsp_bin_in;
   logic [TW-1:0]              rsp_total_ff, rsp_total_in;

   logic                       rsp_free;
   logic                       b_go;
   logic                       wr_en;
   logic [AW-1:0]              b_addr;
   logic [AW-1:0]              q_addr;
   logic [TW-1:0]              old_total;
   logic [TW:0]                sum_wide;
   logic [TW-1:0]              sum;
   logic                       take;
   logic [dtmf_pkg::BIN_W-1:0] new_lead_bin;
   logic [TW-1:0]              new_lead_total;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign b_go     = b_vld_ff && (!b_job_ff.last || rsp_free);
   assign q_pop    = q_valid && (!b_vld_ff || b_go);
   assign wr_en    = b_go && b_job_ff.add_en;
   assign b_addr   = b_job_ff.bin[AW-1:0];
   assign q_addr   = q_job.bin[AW-1:0];

   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == b_addr)) begin
         old_total = fwd_data_ff;
      end else if (valid_ff[b_addr]) begin
         old_total = rd_data_ff;
      end else begin
         old_total = '0;
      end
      sum_wide = {1'b0, old_total} + {1'b0, b_job_ff.amount};
      sum      = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
      take     = b_job_ff.add_en
                 && ((sum > lead_total_ff)
                     || ((sum == lead_total_ff) && (b_job_ff.bin < lead_bin_ff)));
      new_lead_bin   = take ? b_job_ff.bin : lead_bin_ff;
      new_lead_total = take ? sum : lead_total_ff;
   end

   always_comb begin
      b_vld_in      = b_vld_ff;
      b_job_in      = b_job_ff;
      valid_in      = valid_ff;
      fwd_vld_in    = fwd_vld_ff;
      fwd_addr_in   = fwd_addr_ff;
      fwd_data_in   = fwd_data_ff;
      lead_bin_in   = lead_bin_ff;
      lead_total_in = lead_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_total_in  = rsp_total_ff;

      if (q_pop) begin
         b_vld_in = 1'b1;
         b_job_in = q_job;
      end else if (b_go) begin
         b_vld_in = 1'b0;
      end

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (b_go && b_job_ff.last) begin
         valid_in      = '0;
         fwd_vld_in    = 1'b0;
         lead_bin_in   = '0;
         lead_total_in = '0;
         rsp_valid_in  = 1'b1;
         rsp_bin_in    = new_lead_bin;
         rsp_total_in  = new_lead_total;
      end else if (wr_en) begin
         valid_in[b_addr] = 1'b1;
         fwd_vld_in       = 1'b1;
         fwd_addr_in      = b_addr;
         fwd_data_in      = sum;
         lead_bin_in      = new_lead_bin;
         lead_total_in    = new_lead_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff      <= 1'b0;
         valid_ff      <= '0;
         fwd_vld_ff    <= 1'b0;
         lead_bin_ff   <= '0;
         lead_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         b_vld_ff      <= b_vld_in;
         valid_ff      <= valid_in;
         fwd_vld_ff    <= fwd_vld_in;
         lead_bin_ff   <= lead_bin_in;
         lead_total_ff <= lead_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      b_job_ff     <= b_job_in;
      fwd_addr_ff  <= fwd_addr_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff <= mem[q_addr];
      end
      if (wr_en) begin
         mem[b_addr] <= sum;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_bin   = rsp_bin_ff;
   assign rsp_best_total = rsp_total_ff;

   `DTMF_ASSERT_NEXT(a_last_loads_result, clock, reset, b_go && b_job_ff.last, rsp_valid_ff, "final row did not load a result")
   `DTMF_ASSERT_NEXT(a_last_clears_lead, clock, reset, b_go && b_job_ff.last, (lead_total_ff == '0) && (lead_bin_ff == '0) && (valid_ff == '0), "state not cleared after final row")
   `DTMF_ASSERT_NEXT(a_lead_grows, clock, reset, b_go && !b_job_ff.last, lead_total_ff >= $past(lead_total_ff), "leading total decreased")
   `DTMF_ASSERT_NEXT(a_stall_holds_job, clock, reset, b_vld_ff && !b_go, b_vld_ff && $stable(b_job_ff), "held job changed while waiting")

endmodule

`default_nettype wire

// ----- design/dwell_time_mode_finder.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder
// Weighted histogram of clipped dwell intervals with a running argmax.
// ----------------------------------------------------------------------------
// The block sustains one log row per clock while the queue has room. A row is
// classified in the cycle it is accepted; rows that add time or are marked last
// then enter a four-entry queue, and the back end retires one queued job per
// clock, unless a last job waits for the result register, through a bin table
// read-modify-write whose write forwarding sets that rate. A last row's result
// is loaded into the result register once that is free. No clearing pass is
// needed: reset and each last row clear the table at once through per-entry
// valid bits. The request side stalls only while the queue is full, which
// happens only when a result waits behind a stalled result channel.
`default_nettype none

module dwell_time_mode_finder #(
   parameter int NUM_BINS = dtmf_pkg::NUM_BINS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [dtmf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [dtmf_pkg::DATA_W-1:0]     pwdata,
   output logic      [dtmf_pkg::DATA_W-1:0]     prdata,
   output logic                                 pready,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [dtmf_pkg::TIME_W-1:0]     req_row_time,
   input  wire logic [dtmf_pkg::STATUS_W-1:0]   req_row_status,
   input  wire logic [dtmf_pkg::BIN_W-1:0]      req_row_bin,
   input  wire logic                            req_row_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [dtmf_pkg::BIN_W-1:0]      rsp_best_bin,
   output logic      [dtmf_pkg::TIME_W-1:0]     rsp_best_total
);

   dtmf_pkg::cfg_type cfg;
   dtmf_pkg::job_type push_job;
   dtmf_pkg::job_type head_job;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;

   dtmf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dtmf_front #(
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_time   (req_row_time),
      .req_row_status (req_row_status),
      .req_row_bin    (req_row_bin),
      .req_row_last   (req_row_last),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   dtmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   dtmf_back #(
      .NUM_BINS (NUM_BINS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_job          (head_job),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_bin   (rsp_best_bin),
      .rsp_best_total (rsp_best_total)
   );

endmodule

`default_nettype wire

// ----- verif/dtmf_checker.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder checker
// Watches the register port and both item channels. It keeps its own copy of
// the window registers and the per-bin dwell totals, works out the winner of
// every log and compares each returned result with the oldest one owed.
// ----------------------------------------------------------------------------
module dtmf_checker
   import dtmf_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   input  logic                  pready,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [TIME_W-1:0]     req_row_time,
   input  logic [STATUS_W-1:0]   req_row_status,
   input  logic [BIN_W-1:0]      req_row_bin,
   input  logic                  req_row_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [BIN_W-1:0]      rsp_best_bin,
   input  logic [TIME_W-1:0]     rsp_best_total,
   output int                    mismatch_count,
   output int                    winners_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [BIN_W-1:0]  bin;
      logic [TIME_W-1:0] total;
   } winner_t;

   cfg_type             cfg;
   winner_t             winners_due[$];
   winner_t             want;
   logic [TIME_W-1:0]   bin_dwell[NUM_BINS];
   logic [TIME_W-1:0]   prev_stamp;
   logic [STATUS_W-1:0] prev_status;
   logic [BIN_W-1:0]    prev_bin;
   logic                prev_seen;
   logic [BIN_W-1:0]    lead_bin;
   logic [TIME_W-1:0]   lead_total;

   function automatic void clear_log();
      for (int i = 0; i < NUM_BINS; i++) begin
         bin_dwell[i] = '0;
      end
      prev_stamp  = '0;
      prev_status = '0;
      prev_bin    = '0;
      prev_seen   = 1'b0;
      lead_bin    = '0;
      lead_total  = '0;
   endfunction

   function automatic void credit_bin(input logic [BIN_W-1:0] bin,
                                      input logic [TIME_W-1:0] amount);
      logic [TIME_W:0]   wide;
      logic [TIME_W-1:0] sum;
      if (int'(bin) >= NUM_BINS) begin
         return;
      end
      wide = {1'b0, bin_dwell[bin]} + {1'b0, amount};
      sum  = wide[TIME_W] ? '1 : wide[TIME_W-1:0];
      bin_dwell[bin] = sum;
      if (sum > lead_total || (sum == lead_total && bin < lead_bin)) begin
         lead_total = sum;
         lead_bin   = bin;
      end
   endfunction

   function automatic void take_row(input logic [TIME_W-1:0]   stamp,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [BIN_W-1:0]    bin,
                                    input logic                last_row);
      logic [TIME_W-1:0] hi;
      logic [TIME_W-1:0] lo;
      if (prev_seen && prev_status != cfg.stop_code && prev_stamp <= cfg.window_end) begin
         hi = (stamp < cfg.window_end) ? stamp : cfg.window_end;
         lo = (prev_stamp > cfg.window_start) ? prev_stamp : cfg.window_start;
         if (hi > lo) begin
            credit_bin(prev_bin, hi - lo);
         end
      end
      prev_stamp  = stamp;
      prev_status = status;
      prev_bin    = bin;
      prev_seen   = 1'b1;
      if (last_row) begin
         winners_due.push_back('{bin: lead_bin, total: lead_total});
         clear_log();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.window_start = '0;
         cfg.window_end   = '1;
         cfg.stop_code    = '0;
         clear_log();
         winners_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_WINDOW_START: cfg.window_start = pwdata[TIME_W-1:0];
               REG_WINDOW_END:   cfg.window_end   = pwdata[TIME_W-1:0];
               REG_STOP_CODE:    cfg.stop_code    = pwdata[STATUS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (winners_due.size() == 0) begin
               $display("%t: result with none owed: best_bin %0d best_total %0d",
                        $time, rsp_best_bin, rsp_best_total);
               mismatch_count++;
            end else begin
               want = winners_due.pop_front();
               if (rsp_best_bin !== want.bin) begin
                  $display("%t: best_bin expected %0d actual %0d",
                           $time, want.bin, rsp_best_bin);
                  mismatch_count++;
               end
               if (rsp_best_total !== want.total) begin
                  $display("%t: best_total expected %0d actual %0d",
                           $time, want.total, rsp_best_total);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            take_row(req_row_time, req_row_status, req_row_bin, req_row_last);
         end
      end
      winners_owed = winners_due.size();
   end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Dwell-time mode finder testbench
// Streams log rows into the block under a series of window and stop-code
// settings, with random gaps on the row side and random stalls on the result
// side. A directed opening covers empty logs, the stop status, ties, rows out
// of order, saturation and clipping; random logs follow. The checker beside
// the block predicts every winner and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtmf_pkg::*;

   localparam int RANDOM_ROWS = 1950;
   localparam int PHASE_ROWS  = 160;
   localparam int SETTLE_CYC  = 12;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [DATA_W-1:0]     pwdata;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;
   logic                  req_valid;
   logic                  req_stall;
   logic [TIME_W-1:0]     req_row_time;
   logic [STATUS_W-1:0]   req_row_status;
   logic [BIN_W-1:0]      req_row_bin;
   logic                  req_row_last;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BIN_W-1:0]      rsp_best_bin;
   logic [TIME_W-1:0]     rsp_best_total;

   int                    mismatch_count;
   int                    winners_owed;

   logic                  no_idle;
   logic [TIME_W-1:0]     cur_ws;
   logic [STATUS_W-1:0]   cur_stop;
   int                    rows_sent;
   int                    logs_sent;
   int                    settings_used;

   dwell_time_mode_finder dut (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_time   (req_row_time),
      .req_row_status (req_row_status),
      .req_row_bin    (req_row_bin),
      .req_row_last   (req_row_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_bin   (rsp_best_bin),
      .rsp_best_total (rsp_best_total)
   );

   dtmf_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_time   (req_row_time),
      .req_row_status (req_row_status),
      .req_row_bin    (req_row_bin),
      .req_row_last   (req_row_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_bin   (rsp_best_bin),
      .rsp_best_total (rsp_best_total),
      .mismatch_count (mismatch_count),
      .winners_owed   (winners_owed)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         n = no_idle ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_row(input logic [TIME_W-1:0]   stamp,
                           input logic [STATUS_W-1:0] status,
                           input logic [BIN_W-1:0]    bin,
                           input logic                last_row);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_row_time   <= stamp;
      req_row_status <= status;
      req_row_bin    <= bin;
      req_row_last   <= last_row;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      rows_sent++;
      if (last_row) begin
         logs_sent++;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (winners_owed != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_window(input logic [TIME_W-1:0]   ws,
                             input logic [TIME_W-1:0]   we,
                             input logic [STATUS_W-1:0] sc);
      settle();
      csr_write(REG_WINDOW_START, ws);
      csr_write(REG_WINDOW_END, we);
      csr_write(REG_STOP_CODE, {24'd0, sc});
      cur_ws   = ws;
      cur_stop = sc;
      settings_used++;
   endtask

   task automatic send_log(input int len);
      logic [TIME_W-1:0]   stamp;
      logic [STATUS_W-1:0] status;
      logic [BIN_W-1:0]    bin;
      int                  r;
      no_idle = ($urandom_range(0, 4) == 0);
      stamp = $urandom_range(0, 1) ? cur_ws - $urandom_range(0, 3000) : $urandom;
      for (int i = 0; i < len; i++) begin
         status = ($urandom_range(0, 3) == 0) ? cur_stop : 8'($urandom_range(0, 255));
         bin = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
         send_row(stamp, status, bin, i == len - 1);
         r = $urandom_range(0, 59);
         if (r < 3) begin
            stamp = stamp - $urandom_range(1, 500);
         end else if (r < 5) begin
            stamp = $urandom;
         end else begin
            stamp = stamp + $urandom_range(0, 400);
         end
      end
   endtask

   initial begin
      int len;
      int phase;
      int next_phase_at;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_valid      = 1'b0;
      req_row_time   = '0;
      req_row_status = '0;
      req_row_bin    = '0;
      req_row_last   = 1'b0;
      no_idle        = 1'b0;
      cur_ws         = '0;
      cur_stop       = '0;
      rows_sent      = 0;
      logs_sent      = 0;
      settings_used  = 1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // An empty log returns bin zero with zero time.
      send_row(32'd5, 8'd3, 8'd7, 1'b1);
      // Stop status on the first pair; highest bin and status values.
      send_row(32'd100, 8'd0, 8'd1, 1'b0);
      send_row(32'd150, 8'd1, 8'd2, 1'b0);
      send_row(32'd170, 8'd255, 8'd255, 1'b0);
      send_row(32'd200, 8'd2, 8'd3, 1'b1);
      // Equal totals, the higher bin reaching the total first.
      send_row(32'd0, 8'd1, 8'd9, 1'b0);
      send_row(32'd50, 8'd1, 8'd4, 1'b0);
      send_row(32'd100, 8'd1, 8'd0, 1'b1);
      // A row earlier than its predecessor adds nothing.
      send_row(32'd1000, 8'd1, 8'd6, 1'b0);
      send_row(32'd900, 8'd1, 8'd6, 1'b0);
      send_row(32'd950, 8'd1, 8'd2, 1'b0);
      send_row(32'd960, 8'd1, 8'd0, 1'b1);
      // A full-range interval followed by more time saturates the bin.
      send_row(32'd0, 8'd1, 8'd200, 1'b0);
      send_row(32'hFFFF_FFFF, 8'd1, 8'd0, 1'b0);
      send_row(32'd0, 8'd1, 8'd200, 1'b0);
      send_row(32'd10, 8'd1, 8'd1, 1'b1);
      // Clipping at both window edges, a stopped pair and a late predecessor.
      set_window(32'd1000, 32'd2000, 8'd255);
      send_row(32'd500, 8'd0, 8'd1, 1'b0);
      send_row(32'd1500, 8'd255, 8'd2, 1'b0);
      send_row(32'd1800, 8'd7, 8'd3, 1'b0);
      send_row(32'd2500, 8'd7, 8'd4, 1'b0);
      send_row(32'd2600, 8'd7, 8'd5, 1'b1);

      phase         = 0;
      next_phase_at = rows_sent;
      while (rows_sent < next_phase_at + PHASE_ROWS || phase == 0 ||
             rows_sent < RANDOM_ROWS + 21) begin
         if (rows_sent >= next_phase_at) begin
            case (phase)
               0: set_window(32'd0, 32'hFFFF_FFFF, 8'd0);
               1: set_window(32'd0, 32'd0, 8'd255);
               2: set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd128);
               default: begin
                  cur_ws = $urandom;
                  set_window(cur_ws, cur_ws + $urandom_range(0, 6000),
                             8'($urandom_range(0, 255)));
               end
            endcase
            phase++;
            next_phase_at = rows_sent + PHASE_ROWS;
         end
         if (rows_sent >= RANDOM_ROWS + 21) begin
            break;
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
         send_log(len);
      end

      settle();
      $display("Streamed %0d rows in %0d logs under %0d window settings.",
               rows_sent, logs_sent, settings_used);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- dwell_time_mode_finder.f -----
+incdir+design
design/dtmf_pkg.sv
design/dtmf_csr.sv
design/dtmf_front.sv
design/dtmf_queue.sv
design/dtmf_back.sv
design/dwell_time_mode_finder.sv
verif/dtmf_checker.sv
verif/tb.sv
